FILE: hdl/bfil_pkg.sv
// ---------------------------------------------------------------------------
// bfil_pkg
// Shared types and constants of the bloom filter insert/lookup unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bfil_pkg;

  localparam int unsigned FB_W    = 11;  // filter_bytes register width
  localparam int unsigned NH_W    = 6;   // num_hashes register width
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DIV_W   = 14;  // divisor / remainder width (8 * 2047 bits max)
  localparam int unsigned CIDX_W  = 4;
  localparam int unsigned CDAT_W  = 11;
  localparam int unsigned NDIG    = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned DIG_IW  = 4;

  localparam logic [CIDX_W-1:0] REG_FILTER_BYTES = 4'd0;
  localparam logic [CIDX_W-1:0] REG_NUM_HASHES   = 4'd1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [31:0] DJB_SEED   = 32'd5381;
  localparam logic [7:0]  CHAR_MINUS = 8'h2D;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [DIV_W-1:0] DEC_BASE = 14'd10;

  localparam logic [FB_W-1:0] FB_RESET = 11'd1024;
  localparam logic [NH_W-1:0] NH_RESET = 6'd4;

  typedef struct packed {
    logic       init;   // load seeds
    logic       step;   // absorb one character
    logic       fin;    // final mix of the one-at-a-time hash
    logic [7:0] ch;
  } hash_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/bfil_div.sv
// ---------------------------------------------------------------------------
// bfil_div
// Restoring radix-2 divider giving the remainder, one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bfil_div
  import bfil_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [31:0]      dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      rem_o
);

  logic [31:0]      q_q;
  logic [DIV_W-1:0] r_q, dv_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   trial;
  logic             ge;

  assign trial = {r_q, q_q[31]};
  assign ge    = trial >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      q_q    <= '0;
      r_q    <= '0;
      dv_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        q_q    <= dividend_i;
        r_q    <= '0;
        dv_q   <= divisor_i;
      end else if (busy_q) begin
        q_q <= {q_q[30:0], ge};
        r_q <= ge ? DIV_W'(trial - {1'b0, dv_q}) : trial[DIV_W-1:0];
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

FILE: hdl/bfil_hash.sv
// ---------------------------------------------------------------------------
// bfil_hash
// djb2 and one-at-a-time hash registers, one character per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bfil_hash
  import bfil_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hash_ctrl_t ctrl_i,
  output logic [31:0]     djb_o,
  output logic [31:0]     oat_o
);

  logic [31:0] djb_q, oat_q;
  logic [31:0] o1, o2, o3, f1, f2, f3, djb_n;

  always_comb begin
    djb_n = (djb_q << 5) + djb_q + {24'b0, ctrl_i.ch};
    o1 = oat_q + {24'b0, ctrl_i.ch};
    o2 = o1 + (o1 << 10);
    o3 = o2 ^ (o2 >> 6);
    f1 = oat_q + (oat_q << 3);
    f2 = f1 ^ (f1 >> 11);
    f3 = f2 + (f2 << 15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      djb_q <= DJB_SEED;
      oat_q <= '0;
    end else if (ctrl_i.init) begin
      djb_q <= DJB_SEED;
      oat_q <= '0;
    end else if (ctrl_i.step) begin
      djb_q <= djb_n;
      oat_q <= o3;
    end else if (ctrl_i.fin) begin
      oat_q <= f3;
    end
  end

  assign djb_o = djb_q;
  assign oat_o = oat_q;

endmodule

`default_nettype wire

FILE: hdl/bloom_filter_insert_lookup_unit.sv
// ---------------------------------------------------------------------------
// bloom_filter_insert_lookup_unit
// Bloom filter with double hashing over decimal key text; insert or lookup.
// ---------------------------------------------------------------------------
// channel | direction | tdata / data          | tuser / index
// s_axis  | in        | key[31:0]             | cmd
// m_axis  | out       | found (bit 0)         | was_lookup
// cfg     | in        | register value [10:0] | register index [3:0]
//
// each word is split into decimal digits by a reciprocal multiply for
// division by ten, hashed, reduced twice modulo the size and probed; the
// size and probe reductions share one restoring divider. after reset a
// clearing pass writes FILTER_BYTES zero bytes, one a cycle, before the
// first word is taken.
// a finished result waits in the output register until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_lookup_unit
  import bfil_pkg::*;
#(
  parameter int unsigned FILTER_BYTES = 1024,
  parameter int unsigned MAX_HASHES   = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [KEY_W-1:0]  s_axis_tdata,   // key
  input  wire logic              s_axis_tuser,   // cmd
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // found, zero fill
  output logic                   m_axis_tuser,   // was_lookup
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CIDX_W-1:0] cfg_index_i,
  input  wire logic [CDAT_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
  localparam logic [16:0] FB_MAX = 17'(FILTER_BYTES);
  localparam logic [6:0]  K_MAX  = 7'(MAX_HASHES);
  localparam logic [AW-1:0] CLR_LAST = AW'(FILTER_BYTES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIG, ST_NEG, ST_HDIG, ST_FIN, ST_MOD1, ST_MOD2,
    ST_PROBE, ST_PWAIT, ST_MRD, ST_MCHK, ST_RESULT
  } state_e;

  state_e           state_q;
  logic [FB_W-1:0]  fb_q, size_q;
  logic [NH_W-1:0]  nh_q, k_q, i_q;
  logic             cmd_q, neg_q, all_set_q;
  logic [3:0]       dig_q [NDIG];
  logic [DIG_IW-1:0] nd_q, idx_q;
  logic [DIV_W-1:0] h1_q, h2_q;
  logic [31:0]      acc_q;
  logic [AW-1:0]    addr_q, clr_q;
  logic [2:0]       bit_q;
  logic             div_start_q;
  logic [31:0]      div_a_q;
  logic [DIV_W-1:0] div_b_q;
  logic             m_valid_q, found_q, wl_q;
  hash_ctrl_t       hctl;

  logic             div_done;
  logic [DIV_W-1:0] div_rem;
  logic [31:0]      djb, oat;

  logic [63:0]      recip;
  logic [31:0]      dec_quot;
  logic [3:0]       dec_rem;

  logic [7:0]       mem [FILTER_BYTES];
  logic [7:0]       rdata_q;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       wdata;
  logic [7:0]       mask;
  logic [16:0]      byte_w;
  logic [FB_W-1:0]  size_n;
  logic [NH_W-1:0]  k_n;

  bfil_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  bfil_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hctl),
    .djb_o  (djb),
    .oat_o  (oat)
  );

  // magnitude / 10 as (x * 0xCCCCCCCD) >> 35, exact for 32-bit x
  assign recip    = {32'b0, acc_q} * 64'h0000_0000_CCCC_CCCD;
  assign dec_quot = {3'b0, recip[63:35]};
  assign dec_rem  = 4'(acc_q - ((dec_quot << 3) + (dec_quot << 1)));

  always_comb begin
    if (fb_q == '0) begin
      size_n = FB_W'(1);
    end else if ({6'b0, fb_q} > FB_MAX) begin
      size_n = FB_MAX[FB_W-1:0];
    end else begin
      size_n = fb_q;
    end
    k_n = ({1'b0, nh_q} > K_MAX) ? K_MAX[NH_W-1:0] : nh_q;
  end

  always_comb begin
    hctl      = '0;
    hctl.init = (state_q == ST_IDLE);
    case (state_q)
      ST_NEG: begin
        hctl.step = 1'b1;
        hctl.ch   = CHAR_MINUS;
      end
      ST_HDIG: begin
        hctl.step = 1'b1;
        hctl.ch   = CHAR_ZERO + {4'b0, dig_q[idx_q]};
      end
      ST_FIN: hctl.fin = 1'b1;
      default: ;
    endcase
  end

  assign byte_w = 17'(div_rem[DIV_W-1:3]);
  assign mask   = 8'(1) << bit_q;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = rdata_q | mask;
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else if (state_q == ST_MCHK && cmd_q == CMD_INSERT) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      fb_q        <= FB_RESET;
      nh_q        <= NH_RESET;
      clr_q       <= '0;
      div_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
      size_q <= '0; k_q <= '0; i_q <= '0; cmd_q <= 1'b0; neg_q <= 1'b0;
      all_set_q <= 1'b0; nd_q <= '0; idx_q <= '0; h1_q <= '0; h2_q <= '0;
      acc_q <= '0; addr_q <= '0; bit_q <= '0; div_a_q <= '0; div_b_q <= '0;
      found_q <= 1'b0; wl_q <= 1'b0;
      for (int j = 0; j < NDIG; j++) dig_q[j] <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_FILTER_BYTES) begin
          fb_q <= cfg_data_i[FB_W-1:0];
        end else if (cfg_index_i == REG_NUM_HASHES) begin
          nh_q <= cfg_data_i[NH_W-1:0];
        end
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == CLR_LAST) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q       <= s_axis_tuser;
            neg_q       <= s_axis_tdata[31];
            size_q      <= size_n;
            k_q         <= k_n;
            nd_q        <= '0;
            all_set_q   <= 1'b1;
            acc_q       <= s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
            state_q     <= ST_DIG;
          end
        end
        ST_DIG: begin
          dig_q[nd_q] <= dec_rem;
          nd_q        <= nd_q + DIG_IW'(1);
          if (dec_quot != '0) begin
            acc_q <= dec_quot;
          end else begin
            idx_q   <= nd_q;
            state_q <= neg_q ? ST_NEG : ST_HDIG;
          end
        end
        ST_NEG: state_q <= ST_HDIG;
        ST_HDIG: begin
          if (idx_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            idx_q <= idx_q - DIG_IW'(1);
          end
        end
        ST_FIN: begin
          div_a_q     <= djb;
          div_b_q     <= DIV_W'(size_q);
          div_start_q <= 1'b1;
          state_q     <= ST_MOD1;
        end
        ST_MOD1: begin
          if (div_done) begin
            h1_q        <= div_rem;
            div_a_q     <= oat;
            div_start_q <= 1'b1;
            state_q     <= ST_MOD2;
          end
        end
        ST_MOD2: begin
          if (div_done) begin
            h2_q    <= div_rem;
            acc_q   <= 32'(h1_q);
            i_q     <= '0;
            div_b_q <= {size_q, 3'b000};
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (i_q == k_q) begin
            state_q <= ST_RESULT;
          end else begin
            div_a_q     <= acc_q;
            div_start_q <= 1'b1;
            state_q     <= ST_PWAIT;
          end
        end
        ST_PWAIT: begin
          if (div_done) begin
            addr_q  <= byte_w[AW-1:0];
            bit_q   <= div_rem[2:0];
            state_q <= ST_MRD;
          end
        end
        ST_MRD: state_q <= ST_MCHK;
        ST_MCHK: begin
          if (cmd_q == CMD_LOOKUP && (rdata_q & mask) == '0) begin
            all_set_q <= 1'b0;
            state_q   <= ST_RESULT;
          end else begin
            acc_q   <= acc_q + 32'(h2_q);
            i_q     <= i_q + NH_W'(1);
            state_q <= ST_PROBE;
          end
        end
        ST_RESULT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            found_q   <= (cmd_q == CMD_LOOKUP) && all_set_q;
            wl_q      <= cmd_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, found_q};
  assign m_axis_tuser  = wl_q;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the bloom filter insert/lookup unit: random and
// directed inserts and lookups across filter sizes and probe counts, each
// answer compared against a behavioral filter kept in the bench.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import bfil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FBYTES = 1024;
  localparam int unsigned MAXH   = 32;
  localparam int unsigned SETTLE = 4000;  // covers one full word at 32 probes

  typedef struct packed {
    logic found;
    logic was_lookup;
  } answer_t;

  // behavioral filter plus queue of pending answers
  class filter_board;
    logic [7:0] bytes_q [FBYTES];
    logic [FB_W-1:0] size_reg;
    logic [NH_W-1:0] k_reg;
    answer_t pending[$];
    int errors;

    function new();
      foreach (bytes_q[i]) bytes_q[i] = 8'h00;
      size_reg = FB_RESET;
      k_reg = NH_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
      if (idx == REG_FILTER_BYTES) size_reg = val[FB_W-1:0];
      else if (idx == REG_NUM_HASHES) k_reg = val[NH_W-1:0];
    endfunction

    // decimal text of the key, leading minus when negative
    function int key_text(logic [31:0] raw, output logic [7:0] txt [12]);
      logic [7:0] dig [10];
      logic [31:0] mag;
      int nd, n;
      nd = 0;
      n = 0;
      mag = raw;
      if (raw[31]) begin
        txt[n] = CHAR_MINUS;
        n++;
        mag = 32'd0 - raw;
      end
      do begin
        dig[nd] = CHAR_ZERO + 8'(mag % 10);
        mag = mag / 10;
        nd++;
      end while (mag != 0 && nd < 10);
      while (nd > 0) begin
        nd--;
        txt[n] = dig[nd];
        n++;
      end
      return n;
    endfunction

    function void note_word(logic cmd, logic [31:0] key);
      logic [7:0] txt [12];
      logic [31:0] hd, ho, h1, h2, s, kk, nbits, p;
      logic all_set;
      int n;
      answer_t a;
      n = key_text(key, txt);
      s = size_reg;
      if (s == 0) s = 1;
      if (s > FBYTES) s = FBYTES;
      kk = k_reg;
      if (kk > MAXH) kk = MAXH;
      nbits = s * 8;
      hd = DJB_SEED;
      ho = 0;
      for (int i = 0; i < n; i++) begin
        hd = (hd << 5) + hd + txt[i];
        ho = ho + txt[i];
        ho = ho + (ho << 10);
        ho = ho ^ (ho >> 6);
      end
      ho = ho + (ho << 3);
      ho = ho ^ (ho >> 11);
      ho = ho + (ho << 15);
      h1 = hd % s;
      h2 = ho % s;
      all_set = 1'b1;
      for (int i = 0; i < kk; i++) begin
        p = (h1 + i * h2) % nbits;
        if (cmd == CMD_INSERT) bytes_q[p >> 3][p[2:0]] = 1'b1;
        else if (!bytes_q[p >> 3][p[2:0]]) begin
          all_set = 1'b0;
          break;
        end
      end
      a.found = (cmd == CMD_LOOKUP) ? all_set : 1'b0;
      a.was_lookup = cmd;
      pending.push_back(a);
    endfunction

    function void check_word(logic found, logic was_lookup);
      answer_t e;
      if (pending.size() == 0) begin
        $error("unexpected answer found=%0d was_lookup=%0d", found, was_lookup);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (was_lookup !== e.was_lookup) begin
        $error("was_lookup: expected %0d, got %0d", e.was_lookup, was_lookup);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [KEY_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [CDAT_W-1:0] cfg_data_i = '0;

  filter_board board = new();
  bit quiet = 1'b0;  // no idling in the last part of the run
  logic [31:0] recent [$];

  always #5 clk_i = ~clk_i;

  bloom_filter_insert_lookup_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // result side: random stall bursts
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 11);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_word(m_axis_tdata[0], m_axis_tuser);
        if (m_axis_tdata[7:1] !== 7'd0) begin
          $error("tdata fill: expected 0, got %0h", m_axis_tdata[7:1]);
          board.errors++;
        end
      end
    end
  end

  // valid stays up between back-to-back words; the block drops ready on accept
  task automatic send_word(logic cmd, logic [31:0] key);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= key;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(cmd, key);
    if (cmd == CMD_INSERT) begin
      recent.push_back(key);
      if (recent.size() > 40) void'(recent.pop_front());
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 9);
      1: return -$urandom_range(1, 99);
      2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF} ^ $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] key;
    for (int i = 0; i < n; i++) begin
      // lookups of recently inserted keys, which hit under unchanged settings; the rest random
      if (recent.size() != 0 && $urandom_range(0, 2) == 0)
        send_word(CMD_LOOKUP, recent[$urandom_range(0, recent.size() - 1)]);
      else begin
        key = pick_key();
        send_word(1'($urandom_range(0, 1)), key);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: defaults, extremes of the key, both commands
    send_word(CMD_LOOKUP, 32'd0);
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_LOOKUP, 32'd0);
    send_word(CMD_INSERT, 32'h8000_0000);
    send_word(CMD_LOOKUP, 32'h8000_0000);
    send_word(CMD_INSERT, 32'h7FFF_FFFF);
    send_word(CMD_LOOKUP, 32'h7FFF_FFFF);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_word(CMD_LOOKUP, 32'd1_000_000_000);
    // no probes: lookup always hits
    write_cfg(REG_NUM_HASHES, 11'd0);
    send_word(CMD_INSERT, 32'd12345);
    send_word(CMD_LOOKUP, 32'd777);
    // size zero behaves as one byte
    write_cfg(REG_FILTER_BYTES, 11'd0);
    write_cfg(REG_NUM_HASHES, 11'd1);
    send_word(CMD_LOOKUP, 32'd5);
    send_word(CMD_INSERT, 32'd5);
    send_word(CMD_LOOKUP, 32'd6);
    // oversize values saturate; unknown register ignored
    write_cfg(REG_FILTER_BYTES, 11'h7FF);
    write_cfg(REG_NUM_HASHES, 11'h7FF);
    write_cfg(4'hF, 11'h2AA);
    write_cfg(4'h2, 11'h555);
    send_word(CMD_INSERT, 32'd42);
    send_word(CMD_LOOKUP, 32'd42);
    send_word(CMD_LOOKUP, 32'd43);

    // sweep of settings from 1 to 1024 bytes; the small filters make hits occur
    write_cfg(REG_FILTER_BYTES, 11'd1);
    write_cfg(REG_NUM_HASHES, 11'd32);
    random_phase(150);
    write_cfg(REG_FILTER_BYTES, 11'd16);
    write_cfg(REG_NUM_HASHES, 11'd3);
    random_phase(250);
    write_cfg(REG_FILTER_BYTES, 11'd1024);
    write_cfg(REG_NUM_HASHES, 11'd1);
    random_phase(150);
    write_cfg(REG_FILTER_BYTES, 11'd5);
    write_cfg(REG_NUM_HASHES, 11'd33);
    random_phase(150);
    write_cfg(REG_FILTER_BYTES, 11'd1023);
    write_cfg(REG_NUM_HASHES, 11'd4);
    random_phase(150);
    write_cfg(REG_FILTER_BYTES, 11'd64);
    write_cfg(REG_NUM_HASHES, 11'd2);
    random_phase(100);
    drain();
    quiet = 1'b1;
    random_phase(180);
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // ~1150 words plus stalls take well under this
  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
